/* rtl/core/tsb_pkg.sv */
// shared types and codes for the countdown timer slot bank
`default_nettype none
package tsb_pkg;

    localparam int CountW = 32;
    localparam int TagW   = 16;
    localparam int SlotW  = 3;
    localparam int StatW  = 2;
    localparam int CmdW   = 3;
    localparam int SelW   = 8;
    localparam int FireW  = 4;

    localparam logic [FireW-1:0] MaxResults = 4'd8;

    localparam logic [CmdW-1:0] CMD_REG_SEC  = 3'd0;
    localparam logic [CmdW-1:0] CMD_REG_TICK = 3'd1;
    localparam logic [CmdW-1:0] CMD_UNREG    = 3'd2;
    localparam logic [CmdW-1:0] CMD_TICK     = 3'd3;
    localparam logic [CmdW-1:0] CMD_RUN      = 3'd4;

    localparam logic [StatW-1:0] ST_REGISTERED = 2'd0;
    localparam logic [StatW-1:0] ST_NO_SLOT    = 2'd1;
    localparam logic [StatW-1:0] ST_FIRED      = 2'd2;
    localparam logic [StatW-1:0] ST_DONE       = 2'd3;

    localparam logic [0:0] CFG_TICKS_PER_SEC = 1'd0;
    localparam logic [0:0] CFG_TICK_OFFSET   = 1'd1;

    localparam logic [CountW-1:0] TpsReset = 32'd251;
    localparam logic [CountW-1:0] OffReset = 32'd3;

    typedef struct packed {
        logic [TagW-1:0]   tag;
        logic [CountW-1:0] count;
    } t_slot;

endpackage
`default_nettype wire

/* rtl/core/tsb_cell.sv */
// one timer slot of the rotating ring: counter and handler tag
`default_nettype none
module tsb_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  tsb_pkg::t_slot i_slot,
    output tsb_pkg::t_slot o_slot
);
    import tsb_pkg::*;

    logic [CountW-1:0] r_count;
    logic [TagW-1:0]   r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_shift) begin
            r_count <= i_slot.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tag <= i_slot.tag;
        end
    end

    assign o_slot.count = r_count;
    assign o_slot.tag   = r_tag;

endmodule
`default_nettype wire

/* rtl/core/countdown_timer_slot_bank_core.sv */
// countdown timer slot bank: command sequencer around a rotating ring of slot cells
//
// commands arrive on the s_axis channel (tuser = command, tdata = amount, tag,
// slot select); results leave on m_axis (tuser = status, tdata = slot, tag,
// tlast on the final result of a command). registers are written through the
// cfg port, only while the block is idle: a user rule the block does not enforce.
// every known command rotates the ring of SLOT_COUNT cells once, one slot per
// cycle through the head cell unless a fired slot waits on a stalled receiver.
// a seconds registration first passes the multiply stage. an unknown command
// is dropped with no result. register, unregister and tick answer once the
// scan has passed every cell. a run holds each fired slot until the scan finds
// the next one, so the final one leaves at the end of the scan.
// results sit in an output register; when the receiver stalls, the ring halts
// while a further fired slot waits, and no new command is taken until the
// last result of the current one is in the output register.
// reset frees every slot and loads the register defaults (251 and 3).
`default_nettype none
module countdown_timer_slot_bank_core #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // amount[31:0], handler_tag[47:32], slot_select[55:48]
    input  logic [2:0]  s_axis_tuser,  // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // slot[2:0], fired_tag[18:3], zero[23:19]
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    output logic        m_axis_tlast
);
    import tsb_pkg::*;

    localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IdxW-1:0] IdxLast = IdxW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CmdW-1:0]   r_cmd;
    logic [CountW-1:0] r_load, n_load;
    logic [TagW-1:0]   r_tag;
    logic [SelW-1:0]   r_sel;
    logic [IdxW-1:0]   r_idx, n_idx;
    logic              r_found, n_found;
    logic [SlotW-1:0]  r_found_slot, n_found_slot;
    logic [FireW-1:0]  r_fire_cnt, n_fire_cnt;
    logic              r_pend_valid, n_pend_valid;
    logic [SlotW-1:0]  r_pend_slot, n_pend_slot;
    logic [TagW-1:0]   r_pend_tag, n_pend_tag;
    logic              r_out_valid, n_out_valid;
    logic [StatW-1:0]  r_out_status, n_out_status;
    logic [SlotW-1:0]  r_out_slot, n_out_slot;
    logic [TagW-1:0]   r_out_tag, n_out_tag;
    logic              r_out_last, n_out_last;
    logic [CountW-1:0] r_tps, r_off;

    t_slot w_cell_in  [SLOT_COUNT];
    t_slot w_cell_out [SLOT_COUNT];
    t_slot w_head_next;
    logic  w_shift;
    logic  w_out_free;
    logic  w_fire;
    logic  w_accept;
    logic [CountW-1:0] w_load_eff;
    logic [SlotW-1:0]  w_idx_slot;

    // ring of slot cells
    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
            if (g == SLOT_COUNT - 1) begin : g_tail
                assign w_cell_in[g] = w_head_next;
            end else begin : g_mid
                assign w_cell_in[g] = w_cell_out[g+1];
            end
            tsb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_cell_in[g]),
                .o_slot  (w_cell_out[g])
            );
        end
    endgenerate

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_load_eff = (r_load == '0) ? CountW'(1) : r_load;
    assign w_idx_slot = SlotW'(r_idx);
    assign w_fire     = (r_cmd == CMD_RUN) && (w_cell_out[0].count == CountW'(1))
                        && (r_fire_cnt < MaxResults);
    assign w_shift    = (r_state == S_SCAN) && !(w_fire && r_pend_valid && !w_out_free);

    // head cell update
    always_comb begin
        w_head_next = w_cell_out[0];
        case (r_cmd)
            CMD_REG_SEC, CMD_REG_TICK: begin
                if (!r_found && w_cell_out[0].count == '0) begin
                    w_head_next.count = w_load_eff;
                    w_head_next.tag   = r_tag;
                end
            end
            CMD_UNREG: begin
                if (SelW'(r_idx) == r_sel) begin
                    w_head_next.count = '0;
                end
            end
            CMD_TICK: begin
                if (w_cell_out[0].count > CountW'(1)) begin
                    w_head_next.count = w_cell_out[0].count - CountW'(1);
                end
            end
            CMD_RUN: begin
                if (w_fire) begin
                    w_head_next.count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_load       = r_load;
        n_idx        = r_idx;
        n_found      = r_found;
        n_found_slot = r_found_slot;
        n_fire_cnt   = r_fire_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_tag   = r_pend_tag;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_load       = s_axis_tdata[31:0];
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_found_slot = '0;
                    n_fire_cnt   = '0;
                    n_pend_valid = 1'b0;
                    case (s_axis_tuser)
                        CMD_REG_SEC:                       n_state = S_CONV;
                        CMD_REG_TICK, CMD_UNREG, CMD_TICK,
                        CMD_RUN:                           n_state = S_SCAN;
                        default:                           n_state = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                n_load  = r_load * r_tps - r_off;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_shift) begin
                    if ((r_cmd == CMD_REG_SEC || r_cmd == CMD_REG_TICK)
                        && !r_found && w_cell_out[0].count == '0) begin
                        n_found      = 1'b1;
                        n_found_slot = w_idx_slot;
                    end
                    if (w_fire) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_FIRED;
                            n_out_slot   = r_pend_slot;
                            n_out_tag    = r_pend_tag;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = w_idx_slot;
                        n_pend_tag   = w_cell_out[0].tag;
                        n_fire_cnt   = r_fire_cnt + FireW'(1);
                    end
                    if (r_idx == IdxLast) begin
                        n_idx   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + IdxW'(1);
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_slot  = '0;
                    n_out_tag   = '0;
                    n_state     = S_IDLE;
                    if (r_cmd == CMD_REG_SEC || r_cmd == CMD_REG_TICK) begin
                        n_out_status = r_found ? ST_REGISTERED : ST_NO_SLOT;
                        n_out_slot   = r_found ? r_found_slot : '0;
                    end else if (r_cmd == CMD_RUN && r_pend_valid) begin
                        n_out_status = ST_FIRED;
                        n_out_slot   = r_pend_slot;
                        n_out_tag    = r_pend_tag;
                    end else begin
                        n_out_status = ST_DONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_fire_cnt   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tps        <= TpsReset;
            r_off        <= OffReset;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_found      <= n_found;
            r_fire_cnt   <= n_fire_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TICKS_PER_SEC: r_tps <= i_cfg_data;
                    CFG_TICK_OFFSET:   r_off <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= s_axis_tuser;
            r_tag <= s_axis_tdata[47:32];
            r_sel <= s_axis_tdata[55:48];
        end
        r_load       <= n_load;
        r_found_slot <= n_found_slot;
        r_pend_slot  <= n_pend_slot;
        r_pend_tag   <= n_pend_tag;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_tag    <= n_out_tag;
        r_out_last   <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_tag, r_out_slot};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

/* test/tb_countdown_timer_slot_bank_core.sv */
// self-checking testbench for the countdown timer slot bank core
`timescale 1ns / 100ps
`default_nettype none
module tb_countdown_timer_slot_bank_core;
    import tsb_pkg::*;

    localparam int SLOT_COUNT   = 8;
    localparam int IdxW         = $clog2(SLOT_COUNT);
    localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;
    localparam int WATCHDOG     = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 72;
    localparam int NUM_PHASES   = 5;
    localparam int NDIR         = 24;

    localparam logic [CmdW-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CmdW-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CmdW-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic [CmdW-1:0]   cmd;
        logic [CountW-1:0] amount;
        logic [TagW-1:0]   tag;
        logic [SelW-1:0]   sel;
        logic              typed;
        logic [StatW-1:0]  exp_status;
        logic [SlotW-1:0]  exp_slot;
    } t_cmd_row;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [SlotW-1:0] slot;
        logic [TagW-1:0]  tag;
        logic             last;
    } t_timer_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;  // amount[31:0], handler_tag[47:32], slot_select[55:48]
    logic [2:0]  s_axis_tuser;  // command[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;  // slot[2:0], fired_tag[18:3], zero[23:19]
    logic [1:0]  m_axis_tuser;  // status[1:0]
    logic        m_axis_tlast;

    countdown_timer_slot_bank_core #(
        .SLOT_COUNT(SLOT_COUNT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // bank model state
    logic [CountW-1:0] cnt_model [SLOT_COUNT];
    logic [TagW-1:0]   tag_model [SLOT_COUNT];
    logic [CountW-1:0] tps_model;
    logic [CountW-1:0] off_model;
    t_timer_res        step_res [8];
    int                step_n;
    t_timer_res        due_results [$];
    t_timer_res        want_res;

    int errors;
    int quiet = 0;
    bit idle_on;
    bit hold_req;

    t_cmd_row dir_tab [NDIR] = '{
        '{CMD_RUN,      32'd0,          16'h0000, 8'h00, 1'b1, ST_DONE,       3'd0},
        '{CMD_REG_TICK, 32'd0,          16'hFFFF, 8'h00, 1'b1, ST_REGISTERED, 3'd0},
        '{CMD_RUN,      32'd0,          16'h0000, 8'h00, 1'b0, ST_DONE,       3'd0},
        '{CMD_REG_SEC,  32'd0,          16'h1234, 8'h00, 1'b1, ST_REGISTERED, 3'd0},
        '{CMD_REG_SEC,  32'hFFFFFFFF,   16'h8001, 8'h00, 1'b1, ST_REGISTERED, 3'd1},
        '{CMD_REG_TICK, 32'hFFFFFFFF,   16'h0000, 8'h00, 1'b1, ST_REGISTERED, 3'd2},
        '{CMD_REG_TICK, 32'd1,          16'hA5A5, 8'h00, 1'b1, ST_REGISTERED, 3'd3},
        '{CMD_REG_TICK, 32'd2,          16'h5A5A, 8'h00, 1'b1, ST_REGISTERED, 3'd4},
        '{CMD_REG_TICK, 32'd1,          16'h0F0F, 8'h00, 1'b1, ST_REGISTERED, 3'd5},
        '{CMD_REG_TICK, 32'd3,          16'hF0F0, 8'h00, 1'b1, ST_REGISTERED, 3'd6},
        '{CMD_REG_TICK, 32'd1,          16'h7FFF, 8'h00, 1'b1, ST_REGISTERED, 3'd7},
        '{CMD_REG_TICK, 32'd5,          16'h1111, 8'h00, 1'b1, ST_NO_SLOT,    3'd0},
        '{CMD_UNREG,    32'd0,          16'h0000, 8'hFF, 1'b1, ST_DONE,       3'd0},
        '{CMD_UNREG,    32'd0,          16'h0000, 8'h08, 1'b1, ST_DONE,       3'd0},
        '{CMD_UNREG,    32'd0,          16'h0000, 8'h00, 1'b1, ST_DONE,       3'd0},
        '{CMD_UNREG,    32'd0,          16'h0000, 8'h00, 1'b1, ST_DONE,       3'd0},
        '{CMD_RSVD5,    32'hFFFFFFFF,   16'hFFFF, 8'hFF, 1'b0, ST_DONE,       3'd0},
        '{CMD_RSVD6,    32'h0,          16'h0000, 8'h00, 1'b0, ST_DONE,       3'd0},
        '{CMD_RSVD7,    32'h5555AAAA,   16'h3C3C, 8'h01, 1'b0, ST_DONE,       3'd0},
        '{CMD_RUN,      32'd0,          16'h0000, 8'h00, 1'b0, ST_DONE,       3'd0},
        '{CMD_TICK,     32'd0,          16'h0000, 8'h00, 1'b1, ST_DONE,       3'd0},
        '{CMD_RUN,      32'd0,          16'h0000, 8'h00, 1'b0, ST_DONE,       3'd0},
        '{CMD_REG_TICK, 32'd1,          16'hBEEF, 8'h00, 1'b1, ST_REGISTERED, 3'd0},
        '{CMD_RUN,      32'd0,          16'h0000, 8'h00, 1'b0, ST_DONE,       3'd0}
    };

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void step_bank(input t_cmd_row c);
        logic [CountW-1:0] load;
        bit placed;
        step_n = 0;
        case (c.cmd)
            CMD_REG_SEC, CMD_REG_TICK: begin
                if (c.cmd == CMD_REG_SEC) load = c.amount * tps_model - off_model;
                else load = c.amount;
                if (load == '0) load = 32'd1;
                placed = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!placed && cnt_model[i] == '0) begin
                        cnt_model[i] = load;
                        tag_model[i] = c.tag;
                        step_res[0] = '{ST_REGISTERED, i[SlotW-1:0], 16'd0, 1'b1};
                        placed = 1'b1;
                    end
                end
                if (!placed) step_res[0] = '{ST_NO_SLOT, 3'd0, 16'd0, 1'b1};
                step_n = 1;
            end
            CMD_UNREG: begin
                if (c.sel < SLOT_COUNT) cnt_model[c.sel[IdxW-1:0]] = '0;
                step_res[0] = '{ST_DONE, 3'd0, 16'd0, 1'b1};
                step_n = 1;
            end
            CMD_TICK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (cnt_model[i] > 32'd1) cnt_model[i] = cnt_model[i] - 32'd1;
                end
                step_res[0] = '{ST_DONE, 3'd0, 16'd0, 1'b1};
                step_n = 1;
            end
            CMD_RUN: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (cnt_model[i] == 32'd1 && step_n < int'(MaxResults)) begin
                        cnt_model[i] = '0;
                        step_res[step_n] = '{ST_FIRED, i[SlotW-1:0], tag_model[i], 1'b0};
                        step_n++;
                    end
                end
                if (step_n == 0) begin
                    step_res[0] = '{ST_DONE, 3'd0, 16'd0, 1'b1};
                    step_n = 1;
                end else begin
                    step_res[step_n-1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_cmd_row rand_cmd();
        t_cmd_row c;
        int r;
        c = '0;
        r = $urandom_range(0, 99);
        c.amount = $urandom;
        c.tag = TagW'($urandom);
        c.sel = SelW'($urandom);
        if (r < 30) begin
            c.cmd = CMD_REG_TICK;
            if ($urandom_range(0, 3) != 0) c.amount = $urandom_range(0, 6);
        end else if (r < 40) begin
            c.cmd = CMD_REG_SEC;
            if ($urandom_range(0, 3) != 0) c.amount = $urandom_range(0, 3);
        end else if (r < 55) begin
            c.cmd = CMD_UNREG;
            if ($urandom_range(0, 3) != 0)
                c.sel = SelW'($urandom_range(0, SLOT_COUNT - 1));
        end else if (r < 77) begin
            c.cmd = CMD_TICK;
        end else if (r < 95) begin
            c.cmd = CMD_RUN;
        end else begin
            c.cmd = CmdW'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        end
        return c;
    endfunction

    // empty the bank, arm every slot to expire at once, then run
    task automatic add_fire_all(inout t_cmd_row plan [$]);
        t_cmd_row c;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            c = '0;
            c.cmd = CMD_UNREG;
            c.sel = i[SelW-1:0];
            plan.push_back(c);
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            c = '0;
            c.cmd = CMD_REG_TICK;
            c.amount = $urandom_range(0, 1);
            c.tag = TagW'($urandom);
            plan.push_back(c);
        end
        c = '0;
        c.cmd = CMD_RUN;
        plan.push_back(c);
    endtask

    task automatic offer(input t_cmd_row c);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.sel, c.tag, c.amount};
        s_axis_tuser  <= c.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        step_bank(c);
        if (c.typed) begin
            due_results.push_back('{c.exp_status, c.exp_slot, 16'd0, 1'b1});
        end else begin
            for (int k = 0; k < step_n; k++) due_results.push_back(step_res[k]);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_TICKS_PER_SEC) tps_model = val;
        else off_model = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                report($sformatf("unexpected transaction status %0d slot %0d tag %h",
                                 m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3]));
            end else begin
                want_res = due_results.pop_front();
                if (m_axis_tuser !== want_res.status)
                    report($sformatf("status got %0d want %0d", m_axis_tuser,
                                     want_res.status));
                if (m_axis_tdata[2:0] !== want_res.slot)
                    report($sformatf("slot got %0d want %0d", m_axis_tdata[2:0],
                                     want_res.slot));
                if (m_axis_tdata[18:3] !== want_res.tag)
                    report($sformatf("fired tag got %h want %h", m_axis_tdata[18:3],
                                     want_res.tag));
                if (m_axis_tlast !== want_res.last)
                    report($sformatf("last got %0d want %0d", m_axis_tlast,
                                     want_res.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [31:0] tps_set [NUM_PHASES];
        logic [31:0] off_set [NUM_PHASES];
        t_cmd_row plan [$];
        errors = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TICKS_PER_SEC;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_TICK;
        tps_model = TpsReset;
        off_model = OffReset;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            cnt_model[i] = '0;
            tag_model[i] = '0;
        end
        tps_set = '{32'd0, 32'hFFFFFFFF, 32'd1, $urandom, TpsReset};
        off_set = '{32'd0, 32'hFFFFFFFF, 32'd0, $urandom, OffReset};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NDIR; i++) offer(dir_tab[i]);
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_reg(CFG_TICKS_PER_SEC, tps_set[p]);
            write_reg(CFG_TICK_OFFSET, off_set[p]);
            idle_on = (p != NUM_PHASES - 1);
            plan.delete();
            add_fire_all(plan);
            while (plan.size() < PHASE_ITEMS) plan.push_back(rand_cmd());
            // receiver holds off while the sender keeps offering
            if (p == 1) hold_req = 1'b1;
            foreach (plan[k]) offer(plan[k]);
            s_axis_tvalid <= 1'b0;
        end

        settle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/core/tsb_pkg.sv
rtl/core/tsb_cell.sv
rtl/core/countdown_timer_slot_bank_core.sv
test/tb_countdown_timer_slot_bank_core.sv
